// ===== rtl/jfd_pkg.sv =====
// Shared types, constants and the per-byte frame step for the JT808 deframer.
package jfd_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h02;
   localparam logic [7:0] ESC_ESC   = 8'h01;

   localparam logic [3:0] HEADER_BYTES = 4'd12;
   localparam logic [3:0] HDR_ID_HI     = 4'd1;
   localparam logic [3:0] HDR_ID_LO     = 4'd2;
   localparam logic [3:0] HDR_ATTR_HI   = 4'd3;
   localparam logic [3:0] HDR_ATTR_LO   = 4'd4;
   localparam logic [3:0] HDR_SERIAL_HI = 4'd11;
   localparam logic [3:0] HDR_SERIAL_LO = 4'd12;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_BODY     = 3'd0,
      KIND_OK       = 3'd1,
      KIND_BAD_SUM  = 3'd2,
      KIND_BAD_TAIL = 3'd3,
      KIND_TRUNC    = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      PH_HUNT   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_BODY   = 5'b00100,
      PH_CHECK  = 5'b01000,
      PH_TAIL   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] msg_id;
      logic [15:0] msg_serial;
      logic [9:0]  body_length;
      logic [7:0]  data_byte;
      logic [9:0]  byte_index;
      logic        last;
   } rsp_type;

   // Unescaped bytes from one request, plus the buffer end mark.
   typedef struct packed {
      logic       b0_valid;
      logic [7:0] b0;
      logic       b1_valid;
      logic [7:0] b1;
      logic       buffer_end;
   } cmd_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_write_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  header_count;
      logic [15:0] id_reg;
      logic [9:0]  length_reg;
      logic [15:0] serial_reg;
      logic [9:0]  body_count;
      logic [7:0]  xor_acc;
      logic        checksum_ok;
   } frame_state_type;

   typedef struct packed {
      frame_state_type st;
      logic            hit;
      rsp_type         res;
   } step_type;

   function automatic rsp_type make_result(frame_state_type s, kind_type k,
                                           logic [7:0] data, logic [9:0] idx);
      rsp_type r;
      r.kind        = k;
      r.msg_id      = s.id_reg;
      r.msg_serial  = s.serial_reg;
      r.body_length = s.length_reg;
      r.data_byte   = data;
      r.byte_index  = idx;
      r.last        = 1'b0;
      return r;
   endfunction

   // One unescaped byte through the frame state machine.
   function automatic step_type take_byte(frame_state_type s, logic [7:0] b);
      step_type o;
      logic [3:0] hc;
      logic [9:0] bc;
      o     = '0;
      o.st  = s;
      o.res = make_result(s, KIND_BODY, 8'h00, 10'd0);
      hc    = s.header_count + 4'd1;
      bc    = s.body_count + 10'd1;
      case (s.phase)
         PH_HUNT: begin
            if (b == FLAG_BYTE) begin
               o.st       = '0;
               o.st.phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            o.st.header_count = hc;
            o.st.xor_acc      = s.xor_acc ^ b;
            if (hc inside {HDR_ID_HI, HDR_ID_LO}) begin
               o.st.id_reg = {s.id_reg[7:0], b};
            end else if (hc inside {HDR_ATTR_HI, HDR_ATTR_LO}) begin
               o.st.length_reg = {s.length_reg[1:0], b};
            end else if (hc inside {HDR_SERIAL_HI, HDR_SERIAL_LO}) begin
               o.st.serial_reg = {s.serial_reg[7:0], b};
            end
            if (hc >= HEADER_BYTES) begin
               o.st.phase = (o.st.length_reg == 10'd0) ? PH_CHECK : PH_BODY;
            end
         end
         PH_BODY: begin
            o.st.xor_acc    = s.xor_acc ^ b;
            o.hit           = 1'b1;
            o.res           = make_result(s, KIND_BODY, b, s.body_count);
            o.st.body_count = bc;
            if (bc == s.length_reg) begin
               o.st.phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            o.st.checksum_ok = (b == s.xor_acc);
            o.st.phase       = PH_TAIL;
         end
         default: begin
            o.hit = 1'b1;
            if (b != FLAG_BYTE) begin
               o.res = make_result(s, KIND_BAD_TAIL, 8'h00, 10'd0);
            end else if (s.checksum_ok) begin
               o.res = make_result(s, KIND_OK, 8'h00, 10'd0);
            end else begin
               o.res = make_result(s, KIND_BAD_SUM, 8'h00, 10'd0);
            end
            o.st.phase = PH_HUNT;
         end
      endcase
      return o;
   endfunction

endpackage

// ===== rtl/jfd_unescape.sv =====
// Front end: accepts link bytes and undoes the 7D escaping.
module jfd_unescape (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jfd_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              cmd_push,
   output jfd_pkg::cmd_type  cmd_data
);
   import jfd_pkg::*;

   logic esc_ff;
   logic esc_in;
   logic accept;
   logic [7:0] b;

   assign accept = push && !queue_full;
   assign b      = req_data.raw_byte;

   always_comb begin
      esc_in   = esc_ff;
      cmd_data = '0;
      cmd_data.buffer_end = req_data.buffer_end;
      if (esc_ff) begin
         if (b == ESC_FLAG) begin
            esc_in = 1'b0;
            cmd_data.b0_valid = 1'b1;
            cmd_data.b0       = FLAG_BYTE;
         end else if (b == ESC_ESC) begin
            esc_in = 1'b0;
            cmd_data.b0_valid = 1'b1;
            cmd_data.b0       = ESC_BYTE;
         end else if (b == ESC_BYTE) begin
            // The first 7D goes through and the second one stays pending.
            cmd_data.b0_valid = 1'b1;
            cmd_data.b0       = ESC_BYTE;
         end else begin
            esc_in = 1'b0;
            cmd_data.b0_valid = 1'b1;
            cmd_data.b0       = ESC_BYTE;
            cmd_data.b1_valid = 1'b1;
            cmd_data.b1       = b;
         end
      end else if (b == ESC_BYTE) begin
         esc_in = 1'b1;
      end else begin
         cmd_data.b0_valid = 1'b1;
         cmd_data.b0       = b;
      end
      // A buffer end flushes a pending 7D as a plain byte.
      if (req_data.buffer_end && esc_in) begin
         esc_in = 1'b0;
         if (cmd_data.b0_valid) begin
            cmd_data.b1_valid = 1'b1;
            cmd_data.b1       = ESC_BYTE;
         end else begin
            cmd_data.b0_valid = 1'b1;
            cmd_data.b0       = ESC_BYTE;
         end
      end
   end

   assign cmd_push = accept && (cmd_data.b0_valid || cmd_data.buffer_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else if (accept) begin
         esc_ff <= esc_in;
      end
   end

endmodule

// ===== rtl/jfd_cmd_queue.sv =====
// Short queue of unescaped byte groups between the front and back ends.
module jfd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jfd_pkg::cmd_type  push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output jfd_pkg::cmd_type  head
);
   import jfd_pkg::*;

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/jfd_frame_fsm.sv =====
// Back end: runs the frame state machine and produces up to two results per request.
module jfd_frame_fsm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_empty,
   input  jfd_pkg::cmd_type        cmd_head,
   input  logic                    rsp_room,
   output logic                    cmd_pop,
   output jfd_pkg::rsp_write_type  wr
);
   import jfd_pkg::*;

   frame_state_type state_ff, state_in;

   assign cmd_pop = !cmd_empty && rsp_room;

   always_comb begin
      step_type   sa;
      step_type   sb;
      rsp_type    trunc;
      logic [1:0] n;
      sa = '0;
      sb = '0;
      sa.st = state_ff;
      if (cmd_head.b0_valid) begin
         sa = take_byte(state_ff, cmd_head.b0);
      end
      sb.st = sa.st;
      if (cmd_head.b1_valid) begin
         sb = take_byte(sa.st, cmd_head.b1);
      end
      state_in = sb.st;

      wr = '0;
      n  = 2'(sa.hit) + 2'(sb.hit);
      wr.first  = sa.hit ? sa.res : sb.res;
      wr.second = sb.res;

      // An abandoned frame reports truncation; it displaces a second result.
      trunc = make_result(sb.st, KIND_TRUNC, 8'h00, 10'd0);
      if (cmd_head.buffer_end && (sb.st.phase != PH_HUNT)) begin
         state_in.phase = PH_HUNT;
         if (n == 2'd0) begin
            wr.first = trunc;
            n = 2'd1;
         end else begin
            wr.second = trunc;
            n = 2'd2;
         end
      end

      if (n == 2'd1) begin
         wr.first.last = 1'b1;
      end else begin
         wr.second.last = 1'b1;
      end
      wr.count = cmd_pop ? n : 2'd0;
      if (!cmd_pop) begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{PH_HUNT, 4'd0, 16'd0, 10'd0, 16'd0, 10'd0, 8'd0, 1'b0};
      end else begin
         state_ff <= state_in;
      end
   end

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (wr.count == 2'd1) |-> wr.first.last)
      else $error("single result without last flag");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (wr.count == 2'd2) |-> (!wr.first.last && wr.second.last))
      else $error("result pair with wrong last flags");

   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd_head.buffer_end) |=> (state_ff.phase == PH_HUNT))
      else $error("buffer end did not return to hunting");

endmodule

// ===== rtl/jfd_rsp_queue.sv =====
// Result queue: takes up to two results a cycle and delivers one a cycle while popped and not empty.
module jfd_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  jfd_pkg::rsp_write_type  wr,
   input  logic                    pop,
   output logic                    room,
   output logic                    empty,
   output jfd_pkg::rsp_type        head
);
   import jfd_pkg::*;

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_pop;

   assign empty  = (count_ff == '0);
   assign room   = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign do_pop = pop && !empty;
   assign head   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(wr.count);
      rd_ptr_in = do_pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(wr.count) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr.first;
      end
      if (wr.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= wr.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

endmodule

// ===== rtl/jt808_frame_deframer.sv =====
// Top level of the JT808 receive deframer: unescape front end, frame back end, result queue.
// Path: an accepted request is registered in the byte-group queue; the frame machine then
//    writes its results into the result queue, which drives the result ports.
// Throughput: one request per cycle while full is low; a request that yields two results
//    needs two pops on the result side, and the two-entry byte-group queue absorbs the skew.
// Reset: synchronous, active high; it empties both queues, clears a pending escape and
//    returns the frame state machine to hunting with all header fields at zero.
module jt808_frame_deframer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  jfd_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output jfd_pkg::rsp_type  rsp_data
);
   import jfd_pkg::*;

   logic          cmd_push;
   cmd_type       cmd_data;
   logic          cmd_empty;
   cmd_type       cmd_head;
   logic          cmd_pop;
   logic          rsp_room;
   rsp_write_type rsp_wr;

   jfd_unescape u_unescape (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .queue_full (full),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_data)
   );

   jfd_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .full      (full),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   jfd_frame_fsm u_frame_fsm (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .rsp_room  (rsp_room),
      .cmd_pop   (cmd_pop),
      .wr        (rsp_wr)
   );

   jfd_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_wr),
      .pop   (pop),
      .room  (rsp_room),
      .empty (empty),
      .head  (rsp_data)
   );

endmodule

// ===== tb/sv/jt808_frame_deframer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the JT808 deframer: directed table, random frames, predictor.
module jt808_frame_deframer_test;
   import jfd_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_WAIT   = 20000;
   localparam int DRAIN_CYCLES = 20;
   localparam int FREE         = -1;
   localparam int REPORT_MAX   = 10;
   localparam int BIG_CUT_AT   = 52;

   typedef struct {
      logic [7:0] raw;
      logic       brk;
      int         n_typed;
      kind_type   kind_typed;
   } vector_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   // Predictor state, mirroring the frame machine and the escape latch.
   phase_type   fr_phase   = PH_HUNT;
   logic        esc_held   = 1'b0;
   logic [3:0]  hdr_count  = '0;
   logic [15:0] cur_id     = '0;
   logic [9:0]  cur_len    = '0;
   logic [15:0] cur_serial = '0;
   logic [9:0]  body_pos   = '0;
   logic [7:0]  run_xor    = '0;
   logic        sum_match  = 1'b0;

   rsp_type        step_res[$];
   rsp_type        awaited_rsp[$];
   vector_row_type directed_rows[$];

   int fail_count     = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int frame_items    = 0;
   int frames_done    = 0;
   int drain_waited   = 0;
   bit count_on       = 1'b0;

   jt808_frame_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%s", msg);
      end
   endtask

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("kind=%0d id=%h serial=%h len=%0d data=%h idx=%0d last=%b",
                       r.kind, r.msg_id, r.msg_serial, r.body_length, r.data_byte,
                       r.byte_index, r.last);
   endfunction

   task automatic add_result(input kind_type k, input logic [7:0] data,
                             input logic [9:0] idx);
      rsp_type r;
      r.kind        = k;
      r.msg_id      = cur_id;
      r.msg_serial  = cur_serial;
      r.body_length = cur_len;
      r.data_byte   = data;
      r.byte_index  = idx;
      r.last        = 1'b0;
      if (step_res.size() < 3) begin
         step_res.push_back(r);
      end else begin
         step_res[2] = r;
      end
   endtask

   // One unescaped byte through the predicted frame machine.
   task automatic frame_byte(input logic [7:0] b);
      logic [3:0] hc;
      hc = hdr_count + 4'd1;
      case (fr_phase)
         PH_HUNT: begin
            if (b == FLAG_BYTE) begin
               fr_phase   = PH_HEADER;
               hdr_count  = '0;
               cur_id     = '0;
               cur_len    = '0;
               cur_serial = '0;
               body_pos   = '0;
               run_xor    = '0;
               sum_match  = 1'b0;
            end
         end
         PH_HEADER: begin
            hdr_count = hc;
            run_xor   = run_xor ^ b;
            if (hc == HDR_ID_HI || hc == HDR_ID_LO) begin
               cur_id = {cur_id[7:0], b};
            end else if (hc == HDR_ATTR_HI || hc == HDR_ATTR_LO) begin
               cur_len = {cur_len[1:0], b};
            end else if (hc == HDR_SERIAL_HI || hc == HDR_SERIAL_LO) begin
               cur_serial = {cur_serial[7:0], b};
            end
            if (hc >= HEADER_BYTES) begin
               if (cur_len == 10'd0) begin
                  fr_phase = PH_CHECK;
               end else begin
                  fr_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            run_xor = run_xor ^ b;
            add_result(KIND_BODY, b, body_pos);
            body_pos = body_pos + 10'd1;
            if (body_pos == cur_len) begin
               fr_phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            sum_match = (b == run_xor);
            fr_phase  = PH_TAIL;
         end
         default: begin
            if (b != FLAG_BYTE) begin
               add_result(KIND_BAD_TAIL, 8'h00, 10'd0);
            end else if (sum_match) begin
               add_result(KIND_OK, 8'h00, 10'd0);
            end else begin
               add_result(KIND_BAD_SUM, 8'h00, 10'd0);
            end
            fr_phase = PH_HUNT;
         end
      endcase
   endtask

   // Works out the results of one accepted request and queues them.
   task automatic deframe_request(input req_type r);
      logic [7:0] b;
      b = r.raw_byte;
      step_res.delete();
      if (esc_held) begin
         if (b == ESC_FLAG) begin
            esc_held = 1'b0;
            frame_byte(FLAG_BYTE);
         end else if (b == ESC_ESC) begin
            esc_held = 1'b0;
            frame_byte(ESC_BYTE);
         end else if (b == ESC_BYTE) begin
            frame_byte(ESC_BYTE);
         end else begin
            esc_held = 1'b0;
            frame_byte(ESC_BYTE);
            frame_byte(b);
         end
      end else if (b == ESC_BYTE) begin
         esc_held = 1'b1;
      end else begin
         frame_byte(b);
      end
      if (r.buffer_end) begin
         if (esc_held) begin
            esc_held = 1'b0;
            frame_byte(ESC_BYTE);
         end
         if (fr_phase != PH_HUNT) begin
            // The truncation status takes the place of a second body byte.
            while (step_res.size() >= 2) begin
               void'(step_res.pop_back());
            end
            add_result(KIND_TRUNC, 8'h00, 10'd0);
            fr_phase = PH_HUNT;
         end
      end
      while (step_res.size() > 2) begin
         void'(step_res.pop_back());
      end
      if (step_res.size() > 0) begin
         step_res[step_res.size() - 1].last = 1'b1;
      end
      foreach (step_res[i]) begin
         awaited_rsp.push_back(step_res[i]);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_rsp.size() == 0) begin
         note_failure({"ERROR: unexpected result ", rsp_text(got)});
      end else begin
         want = awaited_rsp.pop_front();
         if (got.kind !== want.kind || got.msg_id !== want.msg_id ||
             got.msg_serial !== want.msg_serial || got.body_length !== want.body_length ||
             got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
             got.last !== want.last) begin
            note_failure({"ERROR: expected ", rsp_text(want), "\n       actual   ",
                          rsp_text(got)});
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            check_result(rsp_data);
         end
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_req(input logic [7:0] raw, input logic brk);
      req_type r;
      r.raw_byte   = raw;
      r.buffer_end = brk;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      deframe_request(r);
      if (count_on) begin
         frame_items++;
      end
   endtask

   // Random byte, biased toward the flag, the escape and the escape codes.
   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(15);
      case (r)
         0:       return FLAG_BYTE;
         1:       return ESC_BYTE;
         2:       return ESC_ESC;
         3:       return ESC_FLAG;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Sends one logical byte with standard escaping.
   task automatic send_coded(input logic [7:0] b, input logic brk);
      if (b == FLAG_BYTE || b == ESC_BYTE) begin
         if (brk && $urandom_range(1)) begin
            // Buffer ends between the escape and its code.
            send_req(ESC_BYTE, 1'b1);
         end else begin
            send_req(ESC_BYTE, 1'b0);
            send_req((b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC, brk);
         end
      end else begin
         send_req(b, brk);
      end
   endtask

   task automatic send_frame(input bit big);
      logic [7:0] seq[$];
      logic [7:0] b;
      logic [7:0] sum;
      logic [9:0] blen;
      logic       brk;
      int         r;
      int         p;
      int         cut_at;
      int         open_at;
      bit         open;
      cut_at  = -1;
      open_at = -1;
      open    = 1'b0;
      r       = $urandom_range(99);
      if (big) begin
         blen = 10'h3FF;
      end else if (r < 15) begin
         blen = 10'd0;
      end else if (r < 85) begin
         blen = 10'($urandom_range(6, 1));
      end else begin
         blen = 10'($urandom_range(40, 7));
      end
      seq.push_back(rand_byte());
      seq.push_back(rand_byte());
      b = rand_byte();
      seq.push_back({b[7:2], blen[9:8]});
      seq.push_back(blen[7:0]);
      repeat (8) seq.push_back(rand_byte());
      repeat (blen) seq.push_back(rand_byte());
      // An escape with a plain follower, cut right there, yields more results
      // than fit, so the truncation status must replace a body byte.
      if (!big && blen >= 2 && $urandom_range(4) == 0) begin
         p           = $urandom_range(blen - 2);
         seq[12 + p] = ESC_BYTE;
         seq[13 + p] = 8'($urandom_range(255, 128));
         open_at     = 12 + p;
         cut_at      = 13 + p;
      end
      sum = 8'h00;
      foreach (seq[i]) begin
         sum = sum ^ seq[i];
      end
      if ($urandom_range(5) == 0) begin
         sum = sum ^ 8'(1 << $urandom_range(7));
      end
      seq.push_back(sum);
      if ($urandom_range(7) == 0) begin
         seq.push_back(8'($urandom_range(255)));
      end else begin
         seq.push_back(FLAG_BYTE);
      end
      // The longest body is cut early so that the run stays short.
      if (big) begin
         cut_at = BIG_CUT_AT;
      end
      if (cut_at < 0 && $urandom_range(5) == 0) begin
         cut_at = $urandom_range(seq.size() - 1);
      end

      if ($urandom_range(7) == 0) begin
         send_req(ESC_BYTE, 1'b0);
         send_req(ESC_FLAG, 1'b0);
      end else begin
         send_req(FLAG_BYTE, 1'b0);
      end
      // An escape can be left open so that the next raw byte decides it.
      for (int i = 0; i < seq.size(); i++) begin
         b   = seq[i];
         brk = (i == cut_at);
         if (i == seq.size() - 1) begin
            if (open) begin
               send_req(ESC_ESC, 1'b0);
               open = 1'b0;
            end
            send_req(b, brk);
         end else if (open) begin
            if (b == ESC_BYTE) begin
               send_req(ESC_BYTE, brk);
            end else if (b == FLAG_BYTE || b == ESC_FLAG || b == ESC_ESC) begin
               send_req(ESC_ESC, 1'b0);
               open = 1'b0;
               send_coded(b, brk);
            end else begin
               send_req(b, brk);
               open = 1'b0;
            end
         end else if (b == ESC_BYTE && (i == open_at || $urandom_range(1))) begin
            send_req(ESC_BYTE, brk);
            open = 1'b1;
         end else begin
            send_coded(b, brk);
         end
         if (brk) begin
            break;
         end
      end
   endtask

   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(3, 1)) begin
         b = rand_byte();
         if (b == FLAG_BYTE && $urandom_range(3) != 0) begin
            b = 8'h00;
         end
         send_req(b, ($urandom_range(9) == 0));
      end
   endtask

   task automatic add_row(input logic [7:0] raw, input logic brk, input int n,
                          input kind_type k);
      vector_row_type v;
      v.raw        = raw;
      v.brk        = brk;
      v.n_typed    = n;
      v.kind_typed = k;
      directed_rows.push_back(v);
   endtask

   task automatic build_table();
      // Buffer end and noise while hunting, repeated escape, escape with plain byte.
      add_row(8'h00, 1'b1, 0, KIND_BODY);
      add_row(8'hFF, 1'b0, 0, KIND_BODY);
      add_row(8'h7D, 1'b0, 0, KIND_BODY);
      add_row(8'h7D, 1'b0, 0, KIND_BODY);
      add_row(8'h41, 1'b0, 0, KIND_BODY);
      // Good frame: id 0001, one body byte sent as an escaped flag, serial 1234.
      add_row(8'h7E, 1'b0, 0, KIND_BODY);
      add_row(8'h00, 1'b0, 0, KIND_BODY);
      add_row(8'h01, 1'b0, 0, KIND_BODY);
      add_row(8'h00, 1'b0, 0, KIND_BODY);
      add_row(8'h01, 1'b0, 0, KIND_BODY);
      repeat (6) add_row(8'h00, 1'b0, 0, KIND_BODY);
      add_row(8'h12, 1'b0, 0, KIND_BODY);
      add_row(8'h34, 1'b0, 0, KIND_BODY);
      add_row(8'h7D, 1'b0, 0, KIND_BODY);
      add_row(8'h02, 1'b0, FREE, KIND_BODY);
      add_row(8'h58, 1'b0, 0, KIND_BODY);
      add_row(8'h7E, 1'b0, 1, KIND_OK);
      // Frame opened by an escaped flag, cut at a buffer end with an escape pending.
      add_row(8'h7D, 1'b0, 0, KIND_BODY);
      add_row(8'h02, 1'b0, 0, KIND_BODY);
      add_row(8'hFF, 1'b0, 0, KIND_BODY);
      add_row(8'hFF, 1'b0, 0, KIND_BODY);
      add_row(8'h7D, 1'b1, 1, KIND_TRUNC);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      build_table();
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].raw, directed_rows[i].brk);
         if (directed_rows[i].n_typed != FREE) begin
            if (step_res.size() != directed_rows[i].n_typed ||
                (step_res.size() > 0 &&
                 step_res[step_res.size() - 1].kind != directed_rows[i].kind_typed)) begin
               note_failure($sformatf("ERROR: table row %0d predicts %0d results", i,
                                      step_res.size()));
            end
         end
      end

      count_on = 1'b1;
      while (frame_items < RANDOM_ITEMS) begin
         case (frame_items * 4 / RANDOM_ITEMS)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 81;
            end
            default: begin
               send_idle_pct  = 18;
               recv_stall_pct = 18;
            end
         endcase
         if (frames_done == 2) begin
            send_frame(1'b1);
         end else begin
            send_frame(1'b0);
         end
         if ($urandom_range(3) == 0) begin
            send_noise();
         end
         frames_done++;
      end
      count_on = 1'b0;
      push <= 1'b0;

      while (awaited_rsp.size() > 0 && drain_waited < DRAIN_WAIT) begin
         @(posedge clock);
         drain_waited++;
      end
      if (awaited_rsp.size() > 0) begin
         note_failure($sformatf("ERROR: %0d results never arrived", awaited_rsp.size()));
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
